// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// property that holds in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/rswag_pkg.sv =====
package rswag_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W = $clog2(MAX_DIM) + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DIST_SCALE   = 2'd2
  } cfg_reg_t;

  localparam logic [10:0] WIDTH_RESET = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;
  localparam logic [24:0] SCALE_RESET = 25'd83886;

  localparam int COEF_X0 = 30;
  localparam int COEF_X1 = 40;
  localparam int COEF_Y0 = -35;
  localparam int COEF_Y1 = 40;
  localparam int COEF_RF = 50;
  localparam logic [9:0] OFS_X0 = 10'd100;
  localparam logic [9:0] OFS_X1 = 10'd10;
  localparam logic [9:0] OFS_Y1 = 10'd30;
  localparam logic [9:0] OFS_RF = 10'd70;
  localparam logic [9:0] QUARTER = 10'd256;
  localparam logic [14:0] SINE_ONE = 15'd32767;
  localparam logic [8:0] RING_MAX = 9'd511;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  typedef logic [15:0] qrom_t [0:256];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[125:62];
  endfunction

  function automatic qrom_t build_qrom();
    qrom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] scaled;
    for (int j = 0; j <= 256; j++) begin
      x = (PI_Q62 >> 9) * 64'(j);
      x2 = mul_q62(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 12; n++) begin
        term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      scaled = mul_q62(sum, 64'd32767);
      rom[j] = scaled[15:0];
    end
    rom[0] = 16'd0;
    rom[256] = 16'd32767;
    return rom;
  endfunction

  localparam qrom_t QROM = build_qrom();

  function automatic logic signed [15:0] sine_rom(input logic [9:0] idx);
    logic [15:0] v;
    logic [8:0] j;
    j = {1'b0, idx[7:0]};
    v = idx[8] ? QROM[9'd256 - j] : QROM[j];
    return idx[9] ? -$signed(v) : $signed(v);
  endfunction

endpackage

// ===== src/rswag_pix_if.sv =====
interface rswag_pix_if import rswag_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [9:0] pix_x;
  logic [9:0] pix_y;

  modport source(output valid, req_type, pix_x, pix_y, input ready);
  modport sink(input valid, req_type, pix_x, pix_y, output ready);
endinterface

// ===== src/rswag_addr_if.sv =====
interface rswag_addr_if import rswag_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [9:0]  src_x;
  logic [9:0]  src_y;
  logic [19:0] src_addr;

  modport source(output valid, src_x, src_y, src_addr, input ready);
  modport sink(input valid, src_x, src_y, src_addr, output ready);
endinterface

// ===== src/radial_sine_warp_address_gen.sv =====
// Radial sine warp source-address generator. A pixel request gives one source
// column, row and linear address; a frame-start request updates the warp
// amplitudes, the ring frequency and the frame counter and gives no result. Ten
// register stages (centring, squares, three stages of square root, scaling, ring
// phase, sine displacement, clamp, address); one request enters every clock, and
// the whole pipeline holds while a result waits on the output.
`include "assert_macros.svh"

module radial_sine_warp_address_gen import rswag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rswag_pix_if.sink             pix_in,
  rswag_addr_if.source          addr_out
);

  localparam int NST = 10;

  typedef struct packed {
    logic [9:0] px;
    logic [9:0] py;
  } pos_t;

  typedef struct packed {
    logic [21:0] num;
    logic [22:0] res;
  } sq_t;

  function automatic sq_t sqrt_steps(input sq_t s, input int first, input int count);
    sq_t v;
    logic [22:0] bitv;
    logic [22:0] trial;
    v = s;
    for (int m = 0; m < count; m++) begin
      bitv = 23'd1 << (20 - 2 * (first + m));
      trial = v.res + bitv;
      if ({1'b0, v.num} >= trial) begin
        v.num = v.num - trial[21:0];
        v.res = (v.res >> 1) + bitv;
      end else begin
        v.res = v.res >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic signed [7:0] tz(input logic signed [21:0] m);
    logic [21:0] mag;
    logic [6:0] q0;
    logic [15:0] rem;
    logic [7:0] q;
    mag = m[21] ? 22'(-m) : 22'(m);
    q0 = mag[21:15];
    rem = 16'(mag[14:0]) + 16'(q0);
    q = 8'(q0) + ((rem >= 16'(SINE_ONE)) ? 8'd1 : 8'd0);
    return m[21] ? -$signed(q) : $signed(q);
  endfunction

  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [24:0] dist_scale;
  logic [8:0]  frame_phase;
  logic signed [7:0] amp_x;
  logic signed [7:0] amp_y;
  logic signed [6:0] ring_freq;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic advance;

  logic vld [1:NST];
  logic isp [1:NST];
  pos_t pos [1:NST];

  logic signed [11:0] s1_cx, s1_cy;
  logic signed [15:0] s1_f [0:4];
  logic [21:0] s2_sq;
  logic signed [21:0] s2_m [0:4];
  sq_t s3_sq, s4_sq;
  sq_t s5_sq;
  logic [10:0] s5_r;
  logic [35:0] s6_prod;
  logic signed [16:0] s7_c;
  logic signed [23:0] s8_py, s8_px;
  logic [9:0] s9_sx, s9_sy;
  logic [9:0] s10_sx, s10_sy;
  logic [19:0] s10_addr;
  logic signed [7:0] fa_x [3:7];
  logic signed [7:0] fa_y [3:7];
  logic signed [6:0] fa_r [3:6];

  logic [9:0] t10;
  logic signed [23:0] cx_sq, cy_sq;
  logic [8:0] k6;
  logic [9:0] p7;
  logic signed [11:0] dx8, dy8;
  logic signed [11:0] wlim, hlim;
  logic [20:0] addr9;

  always_comb begin
    w_eff = (frame_width < 11'd2) ? 11'd2 :
            (frame_width > 11'(MAX_DIM)) ? 11'(MAX_DIM) : frame_width;
    h_eff = (frame_height < 11'd2) ? 11'd2 :
            (frame_height > 11'(MAX_DIM)) ? 11'(MAX_DIM) : frame_height;
  end

  assign advance = !(vld[NST] && isp[NST]) || addr_out.ready;
  assign pix_in.ready = advance;
  assign addr_out.valid = vld[NST] && isp[NST];
  assign addr_out.src_x = s10_sx;
  assign addr_out.src_y = s10_sy;
  assign addr_out.src_addr = s10_addr;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      dist_scale <= SCALE_RESET;
      frame_phase <= '0;
      amp_x <= '0;
      amp_y <= '0;
      ring_freq <= '0;
      for (int s = 1; s <= NST; s++) vld[s] <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width <= cfg_data[10:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[10:0];
          REG_DIST_SCALE:   dist_scale <= cfg_data[24:0];
          default: ;
        endcase
      end
      if (advance) begin
        vld[1] <= pix_in.valid;
        for (int s = 2; s <= NST; s++) vld[s] <= vld[s-1];
        if (pix_in.valid && !pix_in.req_type) frame_phase <= frame_phase + 9'd1;
        if (vld[6] && !isp[6]) ring_freq <= fa_r[6];
        if (vld[7] && !isp[7]) begin
          amp_x <= fa_x[7];
          amp_y <= fa_y[7];
        end
      end
    end
  end

  always_comb begin
    t10 = {1'b0, frame_phase};
    cx_sq = s1_cx * s1_cx;
    cy_sq = s1_cy * s1_cy;
    s5_sq = sqrt_steps(s4_sq, 8, 3);
    k6 = (s6_prod[35:25] != '0) ? RING_MAX : s6_prod[24:16];
    p7 = {s7_c[12:4], 1'b0};
    dx8 = 12'(s8_px >>> 15) + $signed({2'b0, pos[8].px});
    dy8 = 12'(s8_py >>> 15) + $signed({2'b0, pos[8].py});
    wlim = $signed({1'b0, w_eff - 11'd2});
    hlim = $signed({1'b0, h_eff - 11'd2});
    addr9 = 21'(s9_sy) * 21'(w_eff) + 21'(s9_sx);
  end

  // datapath
  always_ff @(posedge clk) begin
    if (advance) begin
      isp[1] <= pix_in.req_type;
      pos[1] <= '{px: pix_in.pix_x, py: pix_in.pix_y};
      for (int s = 2; s <= NST; s++) begin
        isp[s] <= isp[s-1];
        pos[s] <= pos[s-1];
      end

      s1_cx <= $signed({2'b0, pix_in.pix_x}) - $signed({2'b0, w_eff[10:1]});
      s1_cy <= $signed({2'b0, pix_in.pix_y}) - $signed({2'b0, h_eff[10:1]});
      s1_f[0] <= sine_rom(10'((t10 + OFS_X0) << 2));
      s1_f[1] <= sine_rom(t10 - OFS_X1);
      s1_f[2] <= sine_rom(10'(t10 << 1));
      s1_f[3] <= sine_rom(t10 + OFS_Y1);
      s1_f[4] <= sine_rom(10'((t10 - OFS_RF) << 3));

      s2_sq <= 22'(cx_sq) + 22'(cy_sq);
      s2_m[0] <= 22'(s1_f[0]) * 22'(COEF_X0);
      s2_m[1] <= 22'(s1_f[1]) * 22'(COEF_X1);
      s2_m[2] <= 22'(s1_f[2]) * 22'(COEF_Y0);
      s2_m[3] <= 22'(s1_f[3]) * 22'(COEF_Y1);
      s2_m[4] <= 22'(s1_f[4]) * 22'(COEF_RF);

      s3_sq <= sqrt_steps('{num: s2_sq, res: '0}, 0, 4);
      fa_x[3] <= tz(s2_m[0]) + tz(s2_m[1]);
      fa_y[3] <= tz(s2_m[2]) + tz(s2_m[3]);
      fa_r[3] <= 7'(tz(s2_m[4]));

      s4_sq <= sqrt_steps(s3_sq, 4, 4);
      s5_r <= s5_sq.res[10:0];
      for (int s = 4; s <= 7; s++) begin
        fa_x[s] <= fa_x[s-1];
        fa_y[s] <= fa_y[s-1];
      end
      for (int s = 4; s <= 6; s++) fa_r[s] <= fa_r[s-1];

      s6_prod <= 36'(s5_r) * 36'(dist_scale);
      s7_c <= $signed({8'b0, k6}) * 17'(ring_freq);
      s8_py <= 24'(sine_rom(p7)) * 24'(amp_y);
      s8_px <= 24'(sine_rom(p7 + QUARTER)) * 24'(amp_x);

      s9_sx <= dx8[11] ? 10'd0 : (dx8 > wlim) ? wlim[9:0] : dx8[9:0];
      s9_sy <= dy8[11] ? 10'd0 : (dy8 > hlim) ? hlim[9:0] : dy8[9:0];

      s10_sx <= s9_sx;
      s10_sy <= s9_sy;
      s10_addr <= addr9[19:0];
    end
  end

  `ASSERT_SAME(a_col_clamped, clk, rst, addr_out.valid, {1'b0, addr_out.src_x} <= w_eff - 11'd2)
  `ASSERT_SAME(a_addr_linear, clk, rst, addr_out.valid, addr_out.src_addr == 20'(21'(addr_out.src_y) * 21'(w_eff) + 21'(addr_out.src_x)))
  `ASSERT_NEXT(a_phase_step, clk, rst, pix_in.valid && pix_in.ready && !pix_in.req_type, frame_phase == $past(frame_phase) + 9'd1)

endmodule
